FILE: rtl/lag_pkg.sv
// Shared field widths and command, reply and register codes for the life automaton.
package lag_pkg;

	localparam int FUNC_W     = 2;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 8;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam int GRID_SIZE_RESET = 256;

endpackage

FILE: rtl/lag_if.sv
// Handshake channels of the life automaton: command items, reply items, register writes.
interface lag_item_if import lag_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic              cell_in;

	modport source (output valid, output func, output col, output row, output cell_in,
		input ready);
	modport sink (input valid, input func, input col, input row, input cell_in,
		output ready);
endinterface

interface lag_reply_if import lag_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] reply_kind;
	logic              cell_out;

	modport source (output valid, output reply_kind, output cell_out, input ready);
	modport sink (input valid, input reply_kind, input cell_out, output ready);
endinterface

interface lag_cfg_if import lag_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/life_automaton_generation.sv
// Top level of the life automaton: command sequencer around a double-banked row store.
//
// Channels: item carries commands (write cell, advance one generation, read cell),
// reply carries results, cfg writes the working width (index 0) and height
// (index 1). cfg is always ready; write it only while the block is idle.
// The grid lives in one row-wide memory holding two banks of MAX_HEIGHT rows;
// bank_q selects the generation that reads and writes see.
// Command flow:
//   - write or read cell: row read issued in the accept cycle, then written back
//     or answered; the next item is taken only after this one finishes.
//   - coordinate error: same timing as a read, reply kind error.
//   - advance: one row read per cycle over all MAX_HEIGHT rows plus one flush,
//     each row computed from a three-row window as its lower neighbor arrives;
//     the reply follows the flush. The single read port sets this pace.
// Reset: the sequencer sweeps bank 0 to all dead, one row per cycle, over all
// MAX_HEIGHT rows; item.ready stays low during the sweep, cfg writes still go.
// Stall: the reply sits in an output register; if the receiver holds off,
// a finishing item that has a reply waits in its last state until the register drains.
module life_automaton_generation import lag_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	lag_cfg_if.sink          cfg,
	lag_item_if.sink         item,
	lag_reply_if.source      reply
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = RW + 1;
	localparam int W_RESET = (GRID_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_SIZE_RESET;
	localparam int H_RESET = (GRID_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_SIZE_RESET;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_GEN    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	// working size, already saturated to 1..MAX
	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	logic [WW-1:0] sat_w;
	logic [HW-1:0] sat_h;

	logic          bank_q;
	logic [RW-1:0] clr_q;

	// latched cell command
	logic [FUNC_W-1:0] func_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic              cell_q;
	logic              err_q;

	// advance walk
	logic [RW:0]            gen_k_q;
	logic                   gen_issue;
	logic                   rd_vld_s1;
	logic [RW:0]            rd_row_s1;
	logic [MAX_WIDTH-1:0]   win_above_q;
	logic [MAX_WIDTH-1:0]   win_cur_q;
	logic [MAX_WIDTH-1:0]   below;
	logic [MAX_WIDTH-1:0]   next_row;
	logic [MAX_WIDTH-1:0]   col_mask;
	logic [RW:0]            wr_row;
	logic                   wr_row_live;

	// memory ports
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [MAX_WIDTH-1:0] rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;

	// reply register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_cell_q;
	logic              out_free;
	logic              out_load;
	logic [KIND_W-1:0] out_kind_d;
	logic              out_cell_d;

	logic in_acc;
	logic in_err;
	logic is_cell_cmd;

	assign cfg.ready   = 1'b1;
	assign item.ready  = (state_q == ST_IDLE);
	assign in_acc      = item.valid & item.ready;
	assign is_cell_cmd = (item.func == FUNC_WRITE) || (item.func == FUNC_READ);
	assign in_err      = (32'(item.col) >= 32'(eff_w_q)) || (32'(item.row) >= 32'(eff_h_q));

	assign reply.valid      = out_valid_q;
	assign reply.reply_kind = out_kind_q;
	assign reply.cell_out   = out_cell_q;
	assign out_free         = ~out_valid_q | reply.ready;

	// saturate register writes: zero reads as one, anything past the store as its size
	always_comb begin
		if (cfg.data == '0) begin
			sat_w = WW'(1);
			sat_h = HW'(1);
		end else begin
			sat_w = (32'(cfg.data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.data);
			sat_h = (32'(cfg.data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.data);
		end
	end

	// columns at or past the working width are dead
	always_comb begin
		for (int c = 0; c < MAX_WIDTH; c++) begin
			col_mask[c] = (32'(c) < 32'(eff_w_q));
		end
	end

	// window: the row just read becomes the lower neighbor; rows past the height read dead
	assign below       = (32'(rd_row_s1) < 32'(eff_h_q)) ? (rd_data & col_mask) : '0;
	assign wr_row      = rd_row_s1 - (RW + 1)'(1);
	assign wr_row_live = (32'(wr_row) < 32'(eff_h_q));
	assign gen_issue   = (state_q == ST_GEN) && (gen_k_q <= (RW + 1)'(MAX_HEIGHT));

	lag_next_row #(
		.W(MAX_WIDTH)
	) u_next_row (
		.above    (win_above_q),
		.cur      (win_cur_q),
		.below    (below),
		.col_mask (col_mask),
		.next     (next_row)
	);

	lag_row_mem #(
		.ADDR_W(AW),
		.DATA_W(MAX_WIDTH)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// read side: one row for a cell command, or the next row of the walk
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {bank_q, gen_k_q[RW-1:0]};
		if (in_acc && is_cell_cmd) begin
			rd_en   = 1'b1;
			rd_addr = {bank_q, RW'(item.row)};
		end else if (gen_issue) begin
			rd_en = 1'b1;
		end
	end

	// write side: clearing sweep, cell write-back, or the next generation into the other bank
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = {bank_q, row_q};
		wr_data        = rd_data;
		wr_data[col_q] = cell_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = {1'b0, clr_q};
				wr_data = '0;
			end
			ST_ACCESS: begin
				wr_en = (func_q == FUNC_WRITE) && !err_q;
			end
			ST_GEN: begin
				if (rd_vld_s1 && (rd_row_s1 != '0)) begin
					wr_en   = 1'b1;
					wr_addr = {~bank_q, wr_row[RW-1:0]};
					wr_data = wr_row_live ? next_row : '0;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// reply selection
	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_DONE;
		out_cell_d = 1'b0;
		case (state_q)
			ST_ACCESS: begin
				if (err_q) begin
					out_load   = out_free;
					out_kind_d = KIND_ERROR;
				end else if (func_q == FUNC_READ) begin
					out_load   = out_free;
					out_kind_d = KIND_READ;
					out_cell_d = rd_data[col_q];
				end
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			bank_q      <= 1'b0;
			eff_w_q     <= WW'(W_RESET);
			eff_h_q     <= HW'(H_RESET);
			gen_k_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			func_q      <= FUNC_WRITE;
			err_q       <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_GRID_WIDTH:  eff_w_q <= sat_w;
					REG_GRID_HEIGHT: eff_h_q <= sat_h;
					default: begin
						eff_w_q <= eff_w_q;
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= gen_issue;
			if (gen_issue) begin
				gen_k_q <= gen_k_q + (RW + 1)'(1);
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(MAX_HEIGHT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						func_q <= item.func;
						err_q  <= in_err;
						if (is_cell_cmd) begin
							state_q <= ST_ACCESS;
						end else if (item.func == FUNC_ADVANCE) begin
							gen_k_q <= '0;
							state_q <= ST_GEN;
						end
					end
				end
				ST_ACCESS: begin
					// a reply that cannot leave yet holds the state; read data stays put
					if (out_load || ((func_q == FUNC_WRITE) && !err_q)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_GEN: begin
					if (rd_vld_s1 && (rd_row_s1 == (RW + 1)'(MAX_HEIGHT))) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						bank_q  <= ~bank_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q  <= RW'(item.row);
			col_q  <= CW'(item.col);
			cell_q <= item.cell_in;
		end
		rd_row_s1 <= gen_k_q;
		if (in_acc && (item.func == FUNC_ADVANCE)) begin
			win_above_q <= '0;
			win_cur_q   <= '0;
		end else if (rd_vld_s1) begin
			win_above_q <= win_cur_q;
			win_cur_q   <= below;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_cell_q <= out_cell_d;
		end
	end

endmodule

FILE: rtl/lag_row_mem.sv
// Row-word store: one write port, one read port with registered read data.
module lag_row_mem #(
	parameter int ADDR_W = 9,
	parameter int DATA_W = 256
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/lag_next_row.sv
// B3/S23 update of one row from the rows above and below it.
module lag_next_row #(
	parameter int W = 256
) (
	input  logic [W-1:0] above,
	input  logic [W-1:0] cur,
	input  logic [W-1:0] below,
	input  logic [W-1:0] col_mask,
	output logic [W-1:0] next
);

	logic [W+1:0] a_p;
	logic [W+1:0] c_p;
	logic [W+1:0] b_p;

	assign a_p = {1'b0, above, 1'b0};
	assign c_p = {1'b0, cur, 1'b0};
	assign b_p = {1'b0, below, 1'b0};

	// count the eight neighbors of each column; padded edges are dead
	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < W; c++) begin
			n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
				+ 4'(c_p[c]) + 4'(c_p[c+2])
				+ 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
			next[c] = col_mask[c] & ((n == 4'd3) | (cur[c] & (n == 4'd2)));
		end
	end

endmodule

FILE: verif/life_automaton_generation_test.sv
// Testbench for the life automaton: directed cell, boundary, size and back-pressure checks, then random generations.
`timescale 1ns / 1ps

module life_automaton_generation_test;
	import lag_pkg::*;

	localparam int MAX_W        = 256;
	localparam int MAX_H        = 256;
	localparam int HALF_PERIOD  = 6;
	// Advance is the slowest command: one row per cycle plus flush.
	localparam int DRAIN_CYCLES = MAX_H + 8;
	// Long receiver hold used to back the block up into its input.
	localparam int LONG_HOLD    = 300;
	// Longest quiet stretch of a correct run is a long hold, an advance or a
	// drain; allow several times the sum before calling it a hang.
	localparam int WATCHDOG_LIMIT = 4 * (LONG_HOLD + MAX_H + 8);

	// The package names the three real commands; code 3 is the unused one.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic              alive;
	} reply_t;

	logic clk;
	logic arst_n;

	lag_cfg_if   cfg_ch ();
	lag_item_if  item_ch ();
	lag_reply_if reply_ch ();

	life_automaton_generation #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.reply  (reply_ch)
	);

	// Shadow of the grid: two banks of row words, plus the bank in use and the
	// raw register values as last written.
	bit [MAX_W-1:0]        life_rows [2][MAX_H];
	bit                    active_bank;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;

	reply_t pending_replies [$];
	int     mismatch_count;
	int     quiet_cycles;

	// Idling controls, written by the test sequence only.
	bit sender_gaps;
	bit receiver_stalls;
	int hold_requests;
	// Written by the reply drain process only.
	int holds_served;

	// Free-running clock: invert every half period.
	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Grid predictor
	// ------------------------------------------------------------------

	// Register values are 9 bits wide: zero means one, anything past the
	// store size saturates at the store size.
	function automatic int size_in_use(logic [CFG_DATA_W-1:0] raw, int limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return int'(raw);
	endfunction

	// Anything outside the working area reads as dead.
	function automatic bit cell_alive(bit bank, int r, int c, int w, int h);
		if (r < 0 || r >= h || c < 0 || c >= w)
			return 1'b0;
		return life_rows[bank][r][c];
	endfunction

	// One B3/S23 step from the current bank into the other one. Every row of
	// the target bank is rewritten, so cells outside the working area die.
	function automatic void advance_generation(int w, int h);
		bit src;
		bit dst;
		int n;
		src = active_bank;
		dst = ~active_bank;
		for (int r = 0; r < MAX_H; r++) begin
			life_rows[dst][r] = '0;
			if (r < h) begin
				for (int c = 0; c < w; c++) begin
					n = 0;
					for (int dr = -1; dr <= 1; dr++)
						for (int dc = -1; dc <= 1; dc++)
							if (dr != 0 || dc != 0)
								n += int'(cell_alive(src, r + dr, c + dc, w, h));
					if (life_rows[src][r][c])
						life_rows[dst][r][c] = (n == 2 || n == 3);
					else
						life_rows[dst][r][c] = (n == 3);
				end
			end
		end
		active_bank = dst;
	endfunction

	// Apply one accepted command to the shadow grid and queue its reply, if any.
	function automatic void predict_reply(logic [FUNC_W-1:0] f, logic [COL_W-1:0] c,
		logic [ROW_W-1:0] r, logic v);
		int w;
		int h;
		w = size_in_use(width_reg, MAX_W);
		h = size_in_use(height_reg, MAX_H);
		if (f == FUNC_ADVANCE) begin
			advance_generation(w, h);
			pending_replies.push_back('{kind: KIND_DONE, alive: 1'b0});
		end else if (f == FUNC_UNUSED) begin
			// ignored: no state change, no reply
		end else if (c >= w || r >= h) begin
			pending_replies.push_back('{kind: KIND_ERROR, alive: 1'b0});
		end else if (f == FUNC_WRITE) begin
			life_rows[active_bank][r][c] = v;
		end else begin
			pending_replies.push_back('{kind: KIND_READ, alive: life_rows[active_bank][r][c]});
		end
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Offer one command item and hold it until accepted; then maybe drop valid
	// for a short burst. Always returns at a rising-edge step.
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [COL_W-1:0] c,
		input logic [ROW_W-1:0] r, input logic v);
		item_ch.valid   <= 1'b1;
		item_ch.func    <= f;
		item_ch.col     <= c;
		item_ch.row     <= r;
		item_ch.cell_in <= v;
		do @(posedge clk); while (!item_ch.ready);
		predict_reply(f, c, r, v);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Write one register; drop valid and wait for a clock edge so that back-to-back
	// writes never lower and raise valid in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_GRID_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering, wait for every reply, then wait out the drain stretch so
	// that a trailing write or ignored item has settled.
	task automatic settle_idle();
		item_ch.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure_grid(input logic [CFG_DATA_W-1:0] w_raw,
		input logic [CFG_DATA_W-1:0] h_raw);
		settle_idle();
		write_reg(REG_GRID_WIDTH, w_raw);
		write_reg(REG_GRID_HEIGHT, h_raw);
	endtask

	// ------------------------------------------------------------------
	// Reply side: ready generation and checking
	// ------------------------------------------------------------------

	// Drive reply ready. A pending hold request parks ready low for the long hold;
	// otherwise stall in short random bursts when enabled.
	initial begin : reply_drain
		reply_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				reply_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				reply_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				reply_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted reply against the oldest prediction.
	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && reply_ch.valid && reply_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: reply_kind %0d cell_out %0b",
					reply_ch.reply_kind, reply_ch.cell_out);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (reply_ch.reply_kind !== want.kind) begin
					$error("reply_kind mismatch: expected %0d, actual %0d",
						want.kind, reply_ch.reply_kind);
					mismatch_count++;
				end
				if (reply_ch.cell_out !== want.alive) begin
					$error("cell_out mismatch: expected %0b, actual %0b",
						want.alive, reply_ch.cell_out);
					mismatch_count++;
				end
			end
		end
	end

	// Hang detector: count cycles in which no channel moves an item.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (item_ch.valid && item_ch.ready) || (reply_ch.valid && reply_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Full-size grid: hit the four corners, overwrite a live cell with dead,
	// and slip in an unused command that must leave no trace.
	task automatic test_cell_access();
		configure_grid(9'd256, 9'd256);
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		send_cmd(FUNC_WRITE, 8'd0,   8'd0,   1'b1);
		send_cmd(FUNC_WRITE, 8'd255, 8'd255, 1'b1);
		send_cmd(FUNC_WRITE, 8'd255, 8'd0,   1'b1);
		send_cmd(FUNC_READ,  8'd0,   8'd0,   1'b0);
		send_cmd(FUNC_READ,  8'd255, 8'd255, 1'b0);
		send_cmd(FUNC_WRITE, 8'd255, 8'd0,   1'b0);
		send_cmd(FUNC_READ,  8'd255, 8'd0,   1'b1);
		send_cmd(FUNC_UNUSED, 8'd0,  8'd255, 1'b1);
		send_cmd(FUNC_READ,  8'd0,   8'd255, 1'b1);
	endtask

	// 3x3 grid: a blinker across the middle row must flip to vertical with the
	// dead boundary; then poke just past the right and bottom edges.
	task automatic test_small_grid_edges();
		configure_grid(9'd3, 9'd3);
		send_cmd(FUNC_WRITE, 8'd0, 8'd1, 1'b1);
		send_cmd(FUNC_WRITE, 8'd1, 8'd1, 1'b1);
		send_cmd(FUNC_WRITE, 8'd2, 8'd1, 1'b1);
		send_cmd(FUNC_ADVANCE, 8'd0, 8'd0, 1'b0);
		send_cmd(FUNC_READ,  8'd1, 8'd0, 1'b0);
		send_cmd(FUNC_READ,  8'd0, 8'd1, 1'b0);
		send_cmd(FUNC_WRITE, 8'd3, 8'd0, 1'b1);
		send_cmd(FUNC_READ,  8'd0, 8'd3, 1'b0);
	endtask

	// Zero width and oversize height clamp to a 1x256 column; oversize width
	// and zero height clamp to a 256x1 row.
	task automatic test_size_saturation();
		configure_grid(9'd0, 9'd511);
		send_cmd(FUNC_WRITE, 8'd0, 8'd255, 1'b1);
		send_cmd(FUNC_READ,  8'd1, 8'd0,   1'b0);
		send_cmd(FUNC_ADVANCE, 8'd0, 8'd0, 1'b0);
		configure_grid(9'd257, 9'd0);
		send_cmd(FUNC_WRITE, 8'd255, 8'd0, 1'b1);
		send_cmd(FUNC_READ,  8'd0,   8'd1, 1'b0);
	endtask

	// A live cell left outside a shrunken area must be dead after an advance
	// once the area grows back over it.
	task automatic test_outside_area_cleared();
		configure_grid(9'd256, 9'd256);
		send_cmd(FUNC_WRITE, 8'd200, 8'd200, 1'b1);
		configure_grid(9'd100, 9'd100);
		send_cmd(FUNC_ADVANCE, 8'd0, 8'd0, 1'b0);
		configure_grid(9'd256, 9'd256);
		send_cmd(FUNC_READ, 8'd200, 8'd200, 1'b0);
	endtask

	// Park reply ready for a long stretch while commands keep coming, so the
	// output register fills and item ready must drop.
	task automatic test_reply_backpressure();
		configure_grid(9'd8, 9'd8);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		hold_requests++;
		for (int i = 0; i < 16; i++)
			send_cmd((i % 4 == 0) ? FUNC_WRITE : FUNC_READ, COL_W'(i % 8),
				ROW_W'((i / 2) % 8), i[0]);
	endtask

	// Random commands over one grid size: mostly seeding writes inside the
	// area, reads and advances, with a sprinkle of stray coordinates and
	// unused commands. Unused commands do not count toward n_items.
	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] w_raw,
		input logic [CFG_DATA_W-1:0] h_raw, input int n_items, input bit gaps, input bit stalls);
		int w;
		int h;
		int pick;
		int done_items;
		int adv_pct;
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
		configure_grid(w_raw, h_raw);
		sender_gaps     = gaps;
		receiver_stalls = stalls;
		w = size_in_use(w_raw, MAX_W);
		h = size_in_use(h_raw, MAX_H);
		// keep full-area advances rare: each one is a long predictor pass
		adv_pct = (w * h > 4096) ? 1 : 10;
		done_items = 0;
		while (done_items < n_items) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) != 0) begin
				c = COL_W'($urandom_range(0, w - 1));
				r = ROW_W'($urandom_range(0, h - 1));
			end else begin
				c = COL_W'($urandom);
				r = ROW_W'($urandom);
			end
			if (pick < adv_pct) begin
				send_cmd(FUNC_ADVANCE, c, r, 1'($urandom_range(0, 1)));
				done_items++;
			end else if (pick < adv_pct + 3) begin
				send_cmd(FUNC_UNUSED, c, r, 1'($urandom_range(0, 1)));
			end else if (pick < 60) begin
				// bias toward live cells so generations have something to do
				send_cmd(FUNC_WRITE, c, r, $urandom_range(0, 4) != 0);
				done_items++;
			end else begin
				send_cmd(FUNC_READ, c, r, 1'($urandom_range(0, 1)));
				done_items++;
			end
		end
	endtask

	task automatic test_random_generations();
		run_random_phase(9'd3,   9'd3,   60, 1'b1, 1'b1);
		run_random_phase(9'd1,   9'd1,   40, 1'b1, 1'b1);
		run_random_phase(9'd8,   9'd5,   60, 1'b1, 1'b0);
		run_random_phase(9'd0,   9'd511, 50, 1'b0, 1'b1);
		run_random_phase(9'd16,  9'd16,  70, 1'b1, 1'b1);
		run_random_phase(9'd300, 9'd2,   50, 1'b1, 1'b1);
		run_random_phase(9'd511, 9'd0,   40, 1'b0, 1'b0);
		run_random_phase(9'd256, 9'd256, 60, 1'b1, 1'b1);
		// closing stretch runs at full rate on both sides
		run_random_phase(9'd12,  9'd20,  80, 1'b0, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : run_tests
		// Hold every input at a known value from time zero.
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.func    <= FUNC_WRITE;
		item_ch.col     <= '0;
		item_ch.row     <= '0;
		item_ch.cell_in <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_GRID_WIDTH;
		cfg_ch.data     <= '0;
		width_reg       = CFG_DATA_W'(GRID_SIZE_RESET);
		height_reg      = CFG_DATA_W'(GRID_SIZE_RESET);
		active_bank     = 1'b0;
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		hold_requests   = 0;
		mismatch_count  = 0;

		// Reset once; the block then sweeps bank 0 with item ready low, which
		// the first command simply waits out.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_cell_access();
		test_small_grid_edges();
		test_size_saturation();
		test_outside_area_cleared();
		test_reply_backpressure();
		test_random_generations();

		settle_idle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/lag_pkg.sv
rtl/lag_if.sv
rtl/lag_row_mem.sv
rtl/lag_next_row.sv
rtl/life_automaton_generation.sv
verif/life_automaton_generation_test.sv
